>>> hw/rtl/nco_bfs_pkg.sv
package nco_bfs_pkg;

  // Sample and table geometry
  localparam int SAMPLE_WIDTH = 16;
  localparam int TABLE_DEPTH  = 1024;
  localparam int TBL_AW       = $clog2(TABLE_DEPTH);
  localparam int QUART_DEPTH  = TABLE_DEPTH / 4;
  localparam int QA_W         = $clog2(QUART_DEPTH);
  localparam int MAG_W        = 15;
  localparam int PHASE_W      = 32;
  localparam int CNT_W        = 17;

  // Configuration register indexes (byte address is 4 * index)
  localparam logic [2:0] REG_PHASE_STEP   = 3'd0;
  localparam logic [2:0] REG_START_PHASE  = 3'd1;
  localparam logic [2:0] REG_BLOCK_LENGTH = 3'd2;
  localparam logic [2:0] REG_SPLIT_POINT  = 3'd3;
  localparam logic [2:0] REG_PHASE_JUMP   = 3'd4;

  localparam logic [CNT_W-1:0] BLOCK_LENGTH_RST = CNT_W'(16384);

  localparam logic [63:0] ONE_Q30     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef logic [MAG_W-1:0] qtab_t [QUART_DEPTH];

  // Magnitude of the sine at quarter-wave position m (1..QUART_DEPTH),
  // Q30 Taylor series up to x^13, rounded half up, limited to full scale.
  function automatic logic [MAG_W-1:0] quarter_sine(input int m);
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] s;
    logic [63:0] v;
    r  = 64'(m) << (30 - QA_W);
    x  = (r * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    s  = ONE_Q30;
    s  = ONE_Q30 - ((x2 * s) >> 30) / 156;
    s  = ONE_Q30 - ((x2 * s) >> 30) / 110;
    s  = ONE_Q30 - ((x2 * s) >> 30) / 72;
    s  = ONE_Q30 - ((x2 * s) >> 30) / 42;
    s  = ONE_Q30 - ((x2 * s) >> 30) / 20;
    s  = ONE_Q30 - ((x2 * s) >> 30) / 6;
    s  = (x * s) >> 30;
    v  = (s * 64'd32768 + (ONE_Q30 >> 1)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[MAG_W-1:0];
  endfunction

  // Entry k holds the magnitude at quarter-wave position k + 1; position 0 is zero.
  function automatic qtab_t build_qtab();
    qtab_t t;
    for (int k = 0; k < QUART_DEPTH; k++) begin
      t[k] = quarter_sine(k + 1);
    end
    return t;
  endfunction

  localparam qtab_t QSIN_TAB = build_qtab();

endpackage

>>> hw/rtl/nco_block_frequency_shifter.sv
// Block frequency shifter: multiplies each complex sample on the input stream by
// exp(j*2*pi*phase) and emits the rotated sample, rounded half up and saturated
// to 16 bits. Phase is a 32-bit fraction of a turn; it restarts at start_phase
// on the first sample of every block of block_length samples (0 counts as 1)
// and advances by phase_step per sample. When split_point is nonzero and below
// the block length, phase_jump is added once at that sample index and carried to
// the end of the block. out_tlast marks the last sample of each block. The block
// takes one sample per clock unless the output stalls; the rate is set by the
// phase accumulator and sample counter at the input stage, with table lookup
// and the complex multiply in the two stages behind it.
// Registers (APB, byte address 4*i): 0 phase_step, 1 start_phase,
// 2 block_length (17 bits), 3 split_point (17 bits), 4 phase_jump. Write them
// only while no transaction is in flight; a new start_phase applies from the
// next block start, the others from the next sample.
module nco_block_frequency_shifter (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // [15:0] in_real, [31:16] in_imag
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [15:0] out_real, [31:16] out_imag
  output logic        out_tlast,   // block_end
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SW = nco_bfs_pkg::SAMPLE_WIDTH;
  localparam int PW = nco_bfs_pkg::PHASE_W;
  localparam int CW = nco_bfs_pkg::CNT_W;
  localparam int AW = nco_bfs_pkg::TBL_AW;
  localparam int QW = nco_bfs_pkg::QA_W;
  localparam int MW = nco_bfs_pkg::MAG_W;
  localparam int SUM_W = 2 * SW + 2;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [PW-1:0] phase_step_r, start_phase_r, phase_jump_r;
  logic [CW-1:0] block_length_r, split_point_r;
  logic          cfg_wr;
  logic [2:0]    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r   <= '0;
      start_phase_r  <= '0;
      block_length_r <= nco_bfs_pkg::BLOCK_LENGTH_RST;
      split_point_r  <= '0;
      phase_jump_r   <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        nco_bfs_pkg::REG_PHASE_STEP:   phase_step_r   <= pwdata;
        nco_bfs_pkg::REG_START_PHASE:  start_phase_r  <= pwdata;
        nco_bfs_pkg::REG_BLOCK_LENGTH: block_length_r <= pwdata[CW-1:0];
        nco_bfs_pkg::REG_SPLIT_POINT:  split_point_r  <= pwdata[CW-1:0];
        nco_bfs_pkg::REG_PHASE_JUMP:   phase_jump_r   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      nco_bfs_pkg::REG_PHASE_STEP:   prdata = phase_step_r;
      nco_bfs_pkg::REG_START_PHASE:  prdata = start_phase_r;
      nco_bfs_pkg::REG_BLOCK_LENGTH: prdata = 32'(block_length_r);
      nco_bfs_pkg::REG_SPLIT_POINT:  prdata = 32'(split_point_r);
      nco_bfs_pkg::REG_PHASE_JUMP:   prdata = phase_jump_r;
      default:                       prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: all stages advance together unless the output is stalled
  // ---------------------------------------------------------------------------
  logic advance;
  logic in_acc;

  assign advance   = !out_tvalid || out_tready;
  assign in_tready = advance;
  assign in_acc    = in_tvalid && advance;

  // ---------------------------------------------------------------------------
  // Phase accumulator and sample counter, updated per accepted transaction
  // ---------------------------------------------------------------------------
  logic [PW-1:0] phase_acc_r, phase_acc_nxt;
  logic [CW-1:0] sample_count_r, sample_count_nxt;
  logic [CW-1:0] blk_len;
  logic [PW-1:0] cur_phase;
  logic          split_hit;
  logic          cur_last;

  always_comb begin
    blk_len   = (block_length_r == '0) ? CW'(1) : block_length_r;
    cur_phase = (sample_count_r != '0) ? phase_acc_r : start_phase_r;
    split_hit = (split_point_r != '0) && (split_point_r < blk_len) &&
                (sample_count_r == split_point_r);
    if (split_hit) begin
      cur_phase = cur_phase + phase_jump_r;
    end
    cur_last         = ({1'b0, sample_count_r} + (CW+1)'(1)) >= {1'b0, blk_len};
    phase_acc_nxt    = cur_phase + phase_step_r;
    sample_count_nxt = cur_last ? '0 : sample_count_r + CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_acc_r    <= '0;
      sample_count_r <= '0;
    end else if (in_acc) begin
      phase_acc_r    <= phase_acc_nxt;
      sample_count_r <= sample_count_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage A: captured sample, its table index and block-end flag
  // ---------------------------------------------------------------------------
  logic                 a_valid_r;
  logic signed [SW-1:0] a_re_r, a_im_r;
  logic [AW-1:0]        a_idx_r;
  logic                 a_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (advance) begin
      a_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_re_r   <= in_tdata[SW-1:0];
      a_im_r   <= in_tdata[2*SW-1:SW];
      a_idx_r  <= cur_phase[PW-1 -: AW];
      a_last_r <= cur_last;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: sine and cosine from the quarter-wave table
  // ---------------------------------------------------------------------------
  // Fold a full-turn index onto the quarter table, then restore the sign.
  function automatic logic signed [SW-1:0] wave_lookup(input logic [AW-1:0] idx);
    logic [1:0]    quad;
    logic [QW-1:0] low;
    logic [QW-1:0] addr;
    logic          zero;
    logic [MW-1:0] mag;
    quad = idx[AW-1 -: 2];
    low  = idx[QW-1:0];
    if (quad[0]) begin
      addr = ~low;
      zero = 1'b0;
    end else begin
      addr = low - QW'(1);
      zero = (low == '0);
    end
    mag = zero ? '0 : nco_bfs_pkg::QSIN_TAB[addr];
    return quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  logic                 b_valid_r;
  logic signed [SW-1:0] b_re_r, b_im_r, b_sin_r, b_cos_r;
  logic                 b_last_r;
  logic [AW-1:0]        cos_idx;

  // cosine is the sine a quarter turn ahead: bump the quadrant bits
  assign cos_idx = a_idx_r + AW'(nco_bfs_pkg::QUART_DEPTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (advance) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && a_valid_r) begin
      b_re_r   <= a_re_r;
      b_im_r   <= a_im_r;
      b_sin_r  <= wave_lookup(a_idx_r);
      b_cos_r  <= wave_lookup(cos_idx);
      b_last_r <= a_last_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage: complex multiply, round half up, shift by 15, saturate
  // ---------------------------------------------------------------------------
  function automatic logic signed [SW-1:0] round_sat(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] rv;
    logic signed [SUM_W-16:0] q;
    rv = v + SUM_W'(16384);
    q  = rv[SUM_W-1:15];
    if (q > (SUM_W-15)'((1 << (SW-1)) - 1)) begin
      return {1'b0, {(SW-1){1'b1}}};
    end else if (q < -$signed((SUM_W-15)'(1 << (SW-1)))) begin
      return {1'b1, {(SW-1){1'b0}}};
    end
    return q[SW-1:0];
  endfunction

  logic signed [2*SW-1:0]  p_rc, p_is, p_rs, p_ic;
  logic signed [SUM_W-1:0] sum_re, sum_im;

  always_comb begin
    p_rc   = b_re_r * b_cos_r;
    p_is   = b_im_r * b_sin_r;
    p_rs   = b_re_r * b_sin_r;
    p_ic   = b_im_r * b_cos_r;
    sum_re = SUM_W'(p_rc) - SUM_W'(p_is);
    sum_im = SUM_W'(p_rs) + SUM_W'(p_ic);
  end

  logic                 out_valid_r;
  logic signed [SW-1:0] out_re_r, out_im_r;
  logic                 out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && b_valid_r) begin
      out_re_r   <= round_sat(sum_re);
      out_im_r   <= round_sat(sum_im);
      out_last_r <= b_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_im_r, out_re_r};
  assign out_tlast  = out_last_r;

endmodule
